### src/vnht_pkg.sv
// shared types, constants and codes of the variable name hash table
`timescale 1ns / 1ps

package vnht_pkg;

  // table geometry
  localparam int TableSize = 256;
  localparam int IdxW      = $clog2(TableSize);
  localparam int NameBytes = 16;
  localparam int NameW     = 8 * NameBytes;
  localparam int LenW      = 5;
  localparam int TypeW     = 3;
  localparam int SlotW     = 8;

  // hash constants
  localparam int HashMul  = 179;
  localparam int BaseChar = 65;

  // request queue depth
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // action codes (code three behaves as find or create)
  localparam logic [1:0] ActFind   = 2'd0;
  localparam logic [1:0] ActCreate = 2'd1;
  localparam logic [1:0] ActClear  = 2'd2;

  // result status codes
  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_CREATED   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } vnht_status_t;

  // back end states
  typedef enum logic {
    BK_IDLE,
    BK_PROBE
  } vnht_state_t;

  // classified request passed from front to back
  typedef struct packed {
    logic [1:0]      action;
    logic [63:0]     name_low;
    logic [63:0]     name_high;
    logic [LenW-1:0] name_length;
    logic [TypeW-1:0] var_type;
    logic [IdxW-1:0] hash;
  } vnht_req_t;

  // stored slot contents
  typedef struct packed {
    logic [TypeW-1:0] var_type;
    logic [LenW-1:0]  name_length;
    logic [63:0]      name_low;
    logic [63:0]      name_high;
  } vnht_entry_t;

endpackage

### src/vnht_front.sv
// front end: name normalization, hash and request register
`timescale 1ns / 1ps

module vnht_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_action,
  input  logic [63:0]              in_name_low,
  input  logic [63:0]              in_name_high,
  input  logic [vnht_pkg::LenW-1:0]  in_name_length,
  input  logic [vnht_pkg::TypeW-1:0] in_var_type,
  output logic                     req_valid,
  input  logic                     req_ready,
  output vnht_pkg::vnht_req_t      req
);

  logic                          valid_r;
  vnht_pkg::vnht_req_t           req_r;
  logic [vnht_pkg::LenW-1:0]     len_c;
  logic [vnht_pkg::NameW-1:0]    raw_c;
  logic [vnht_pkg::NameW-1:0]    name_c;
  logic [vnht_pkg::IdxW-1:0]     hash_c;
  vnht_pkg::vnht_req_t           req_c;

  // clamp length, drop bytes past it, sum the weighted bytes
  always_comb begin
    len_c = (in_name_length > vnht_pkg::LenW'(vnht_pkg::NameBytes)) ?
            vnht_pkg::LenW'(vnht_pkg::NameBytes) : in_name_length;
    raw_c  = {in_name_high, in_name_low};
    name_c = '0;
    hash_c = '0;
    for (int i = 0; i < vnht_pkg::NameBytes; i++) begin
      if (vnht_pkg::LenW'(i) < len_c) begin
        name_c[i*8 +: 8] = raw_c[i*8 +: 8];
        // only bytes inside the name take part in the sum
        hash_c = hash_c + (vnht_pkg::IdxW'(name_c[i*8 +: 8]) -
                           vnht_pkg::IdxW'(vnht_pkg::BaseChar)) *
                          vnht_pkg::IdxW'(i * vnht_pkg::HashMul);
      end
    end
    req_c.action      = in_action;
    req_c.name_low    = name_c[63:0];
    req_c.name_high   = name_c[127:64];
    req_c.name_length = len_c;
    req_c.var_type    = in_var_type;
    req_c.hash        = hash_c;
  end

  assign in_ready  = !valid_r || req_ready;
  assign req_valid = valid_r;
  assign req       = req_r;

  // request valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= req_c;
    end
  end

endmodule

### src/vnht_queue.sv
// short request queue between front and back
`timescale 1ns / 1ps

module vnht_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  vnht_pkg::vnht_req_t push_req,
  output logic                pop_valid,
  input  logic                pop_ready,
  output vnht_pkg::vnht_req_t pop_req
);

  vnht_pkg::vnht_req_t          slots_r [vnht_pkg::QDepth];
  logic [vnht_pkg::QPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [vnht_pkg::QPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [vnht_pkg::QCntW-1:0]   count_r, count_nxt;
  logic                         do_push, do_pop;

  assign push_ready = (count_r != vnht_pkg::QCntW'(vnht_pkg::QDepth));
  assign pop_valid  = (count_r != '0);
  assign pop_req    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == vnht_pkg::QPtrW'(vnht_pkg::QDepth - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == vnht_pkg::QPtrW'(vnht_pkg::QDepth - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

### src/vnht_back.sv
// back end: slot memory, triangular probe sequencer and result register
`timescale 1ns / 1ps

module vnht_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  vnht_pkg::vnht_req_t      req,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [vnht_pkg::SlotW-1:0] out_slot_index,
  output logic [2:0]               out_status
);

  vnht_pkg::vnht_state_t          state_r, state_nxt;
  logic [vnht_pkg::TableSize-1:0] used_r, used_nxt;
  vnht_pkg::vnht_req_t            req_r, req_nxt;
  logic [vnht_pkg::IdxW-1:0]      pos_r, pos_nxt;
  logic [vnht_pkg::IdxW-1:0]      step_r, step_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [vnht_pkg::SlotW-1:0]     out_idx_r, out_idx_nxt;
  vnht_pkg::vnht_status_t         out_status_r, out_status_nxt;

  vnht_pkg::vnht_entry_t          mem [vnht_pkg::TableSize];
  vnht_pkg::vnht_entry_t          rdata_r;
  vnht_pkg::vnht_entry_t          wdata_c;
  logic [vnht_pkg::IdxW-1:0]      rd_addr_c;
  logic                           we_c;
  logic                           out_free_c;
  logic                           match_c;

  assign out_free_c = !out_valid_r || out_ready;

  // stored entry equals the request
  assign match_c = (rdata_r.var_type == req_r.var_type) &&
                   (rdata_r.name_length == req_r.name_length) &&
                   (rdata_r.name_low == req_r.name_low) &&
                   (rdata_r.name_high == req_r.name_high);

  assign wdata_c.var_type    = req_r.var_type;
  assign wdata_c.name_length = req_r.name_length;
  assign wdata_c.name_low    = req_r.name_low;
  assign wdata_c.name_high   = req_r.name_high;

  // probe sequencer
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    req_nxt        = req_r;
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_idx_nxt    = out_idx_r;
    out_status_nxt = out_status_r;
    rd_addr_c      = pos_r;
    we_c           = 1'b0;
    req_ready      = 1'b0;
    unique case (state_r)
      vnht_pkg::BK_IDLE: begin
        if (req_valid && out_free_c) begin
          req_ready = 1'b1;
          req_nxt   = req;
          if (req.action == vnht_pkg::ActClear) begin
            used_nxt       = '0;
            out_valid_nxt  = 1'b1;
            out_idx_nxt    = '0;
            out_status_nxt = vnht_pkg::ST_CLEARED;
          end else begin
            rd_addr_c = req.hash;
            pos_nxt   = req.hash;
            step_nxt  = '0;
            state_nxt = vnht_pkg::BK_PROBE;
          end
        end
      end
      vnht_pkg::BK_PROBE: begin
        if (!used_r[pos_r]) begin
          // free slot: create the entry here
          we_c             = 1'b1;
          used_nxt[pos_r]  = 1'b1;
          out_valid_nxt    = 1'b1;
          out_idx_nxt      = vnht_pkg::SlotW'(pos_r);
          out_status_nxt   = vnht_pkg::ST_CREATED;
          state_nxt        = vnht_pkg::BK_IDLE;
        end else if (match_c) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = vnht_pkg::SlotW'(pos_r);
          out_status_nxt = (req_r.action == vnht_pkg::ActCreate) ?
                           vnht_pkg::ST_DUPLICATE : vnht_pkg::ST_FOUND;
          state_nxt      = vnht_pkg::BK_IDLE;
        end else if (step_r == vnht_pkg::IdxW'(vnht_pkg::TableSize - 2)) begin
          // probe budget spent
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = '0;
          out_status_nxt = vnht_pkg::ST_FULL;
          state_nxt      = vnht_pkg::BK_IDLE;
        end else begin
          step_nxt  = step_r + 1'b1;
          pos_nxt   = pos_r + step_r + 1'b1;
          rd_addr_c = pos_r + step_r + 1'b1;
        end
      end
      default: begin
        state_nxt = vnht_pkg::BK_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vnht_pkg::BK_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working payload and result data
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    pos_r        <= pos_nxt;
    step_r       <= step_nxt;
    out_idx_r    <= out_idx_nxt;
    out_status_r <= out_status_nxt;
  end

  // slot memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[pos_r] <= wdata_c;
    end
    rdata_r <= mem[rd_addr_c];
  end

  assign out_valid      = out_valid_r;
  assign out_slot_index = out_idx_r;
  assign out_status     = out_status_r;

endmodule

### src/variable_name_hash_table_core.sv
// top level of the variable name hash table
//
// Symbol table of 256 slots keyed by a name of up to 16 bytes and a type code.
// Input channel (in_valid/in_ready): action, name bytes, name length, type.
// Output channel (out_valid/out_ready): slot index and status, one result
// beat per input beat, in input order.
// A lookup's input beat passes the front register and the queue before the
// back end takes it; its result is registered by the probe that ends it, a
// clear's result as the back end takes it. The back end works on one request
// at a time and takes the next only back in its idle state, so the probe loop
// over the slot memory sets the rate at which items complete.
// A two-entry queue sits between the hashing front end and the probe back
// end, so new beats are taken while a lookup is probing.
// Reset empties the table (all slot used bits cleared) and drops any
// queued beats. When the receiver holds out_ready low the result stays
// in its register; the back end waits and in_ready falls once the front
// register and the queue are full.
`timescale 1ns / 1ps

module variable_name_hash_table_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_action,
  input  logic [63:0]              in_name_low,
  input  logic [63:0]              in_name_high,
  input  logic [vnht_pkg::LenW-1:0]  in_name_length,
  input  logic [vnht_pkg::TypeW-1:0] in_var_type,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [vnht_pkg::SlotW-1:0] out_slot_index,
  output logic [2:0]               out_status
);

  logic                f2q_valid, f2q_ready;
  vnht_pkg::vnht_req_t f2q_req;
  logic                q2b_valid, q2b_ready;
  vnht_pkg::vnht_req_t q2b_req;

  // normalize and hash
  vnht_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_name_low    (in_name_low),
    .in_name_high   (in_name_high),
    .in_name_length (in_name_length),
    .in_var_type    (in_var_type),
    .req_valid      (f2q_valid),
    .req_ready      (f2q_ready),
    .req            (f2q_req)
  );

  // decoupling queue
  vnht_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f2q_valid),
    .push_ready (f2q_ready),
    .push_req   (f2q_req),
    .pop_valid  (q2b_valid),
    .pop_ready  (q2b_ready),
    .pop_req    (q2b_req)
  );

  // probe and update
  vnht_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (q2b_valid),
    .req_ready      (q2b_ready),
    .req            (q2b_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_slot_index (out_slot_index),
    .out_status     (out_status)
  );

endmodule

### dv/testbench.sv
// self-checking testbench of the variable name hash table core
`timescale 1ns / 1ps

module testbench;
  import vnht_pkg::*;

  // unused action code, the block treats it as find or create
  localparam logic [1:0] ActAlias = 2'd3;

  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 300;
  localparam int LongHold    = 200;
  localparam int PoolSize    = 32;
  localparam int MaxReports  = 10;

  // one row of the directed stimulus, with an optional hand-written result
  typedef struct {
    logic [1:0]       action;
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [LenW-1:0]  len;
    logic [TypeW-1:0] vtype;
    bit               typed;
    logic [SlotW-1:0] slot;
    vnht_status_t     status;
  } dir_row_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    vnht_status_t     status;
  } slot_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_action;
  logic [63:0]       in_name_low;
  logic [63:0]       in_name_high;
  logic [LenW-1:0]   in_name_length;
  logic [TypeW-1:0]  in_var_type;
  logic              out_valid;
  logic              out_ready;
  logic [SlotW-1:0]  out_slot_index;
  logic [2:0]        out_status;

  // hand-written result that travels with the current input beat
  bit                beat_typed;
  logic [SlotW-1:0]  beat_slot;
  vnht_status_t      beat_status;

  // shadow copy of the symbol table
  bit                tbl_used [TableSize];
  logic [TypeW-1:0]  tbl_type [TableSize];
  logic [LenW-1:0]   tbl_len  [TableSize];
  logic [63:0]       tbl_lo   [TableSize];
  logic [63:0]       tbl_hi   [TableSize];

  // names reused by the random part so that lookups hit
  logic [63:0]       pool_lo   [PoolSize];
  logic [63:0]       pool_hi   [PoolSize];
  int                pool_len  [PoolSize];
  logic [TypeW-1:0]  pool_type [PoolSize];

  dir_row_t          directed_rows [$];
  slot_result_t      expected_results [$];
  int                status_tally [5];
  int                items_taken = 0;
  int                results_seen = 0;
  int                fail_count = 0;
  int                stall_cycles = 0;
  bit                calm = 1'b0;
  bit                hold_pending = 1'b0;

  variable_name_hash_table_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_name_low    (in_name_low),
    .in_name_high   (in_name_high),
    .in_name_length (in_name_length),
    .in_var_type    (in_var_type),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_slot_index (out_slot_index),
    .out_status     (out_status)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mask that keeps the first n bytes of a word
  function automatic logic [63:0] byte_mask(input int n);
    if (n <= 0) return 64'd0;
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= MaxReports) $display("mismatch: %s", what);
  endtask

  // table lookup: clear, or hash, triangular probe, then create or report
  task automatic lookup_symbol(input logic [1:0] act, input logic [63:0] lo_in,
                               input logic [63:0] hi_in, input logic [LenW-1:0] len_in,
                               input logic [TypeW-1:0] vt, output slot_result_t res);
    int n;
    int sum;
    int b;
    int pos;
    bit hit;
    logic [LenW-1:0] n5;
    logic [63:0] lo;
    logic [63:0] hi;
    if (act == ActClear) begin
      for (int s = 0; s < TableSize; s++) tbl_used[s] = 1'b0;
      res.slot = '0;
      res.status = ST_CLEARED;
      return;
    end
    n = (int'(len_in) > NameBytes) ? NameBytes : int'(len_in);
    n5 = LenW'(n);
    lo = lo_in & byte_mask(n);
    hi = hi_in & byte_mask(n - 8);
    // signed weighted sum of the name bytes
    sum = 0;
    for (int i = 0; i < n; i++) begin
      if (i < 8) b = int'(lo[8 * i +: 8]);
      else b = int'(hi[8 * (i - 8) +: 8]);
      sum += (b - BaseChar) * i * HashMul;
    end
    pos = sum & (TableSize - 1);
    // probe h, h+1, h+3, h+6, ... for a free or matching slot
    hit = 1'b0;
    for (int step = 0; step < TableSize - 1; step++) begin
      pos = (pos + step) & (TableSize - 1);
      if (!tbl_used[pos] || (tbl_type[pos] == vt && tbl_len[pos] == n5 &&
                             tbl_lo[pos] == lo && tbl_hi[pos] == hi)) begin
        hit = 1'b1;
        break;
      end
    end
    if (!hit) begin
      res.slot = '0;
      res.status = ST_FULL;
    end else begin
      res.slot = pos[SlotW-1:0];
      if (tbl_used[pos]) begin
        res.status = (act == ActCreate) ? ST_DUPLICATE : ST_FOUND;
      end else begin
        tbl_used[pos] = 1'b1;
        tbl_type[pos] = vt;
        tbl_len[pos] = n5;
        tbl_lo[pos] = lo;
        tbl_hi[pos] = hi;
        res.status = ST_CREATED;
      end
    end
  endtask

  task automatic add_row(input logic [1:0] act, input logic [63:0] lo, input logic [63:0] hi,
                         input logic [LenW-1:0] len, input logic [TypeW-1:0] vt,
                         input bit typed, input logic [SlotW-1:0] slot,
                         input vnht_status_t st);
    dir_row_t row;
    row.action = act;
    row.lo = lo;
    row.hi = hi;
    row.len = len;
    row.vtype = vt;
    row.typed = typed;
    row.slot = slot;
    row.status = st;
    directed_rows.push_back(row);
  endtask

  // drive one input beat, called at a falling edge, returns at a falling edge
  task automatic offer_request(input logic [1:0] act, input logic [63:0] lo,
                               input logic [63:0] hi, input logic [LenW-1:0] len,
                               input logic [TypeW-1:0] vt, input bit typed,
                               input logic [SlotW-1:0] slot, input vnht_status_t st);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_name_low    <= lo;
    in_name_high   <= hi;
    in_name_length <= len;
    in_var_type    <= vt;
    beat_typed     <= typed;
    beat_slot      <= slot;
    beat_status    <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // pick a pooled name with random bytes past its length, or pure noise
  task automatic make_pool_request(output logic [1:0] act, output logic [63:0] lo,
                                   output logic [63:0] hi, output logic [LenW-1:0] len,
                                   output logic [TypeW-1:0] vt);
    int k;
    int r;
    int n;
    k = $urandom_range(0, PoolSize - 1);
    r = $urandom_range(0, 99);
    n = pool_len[k];
    lo = (pool_lo[k] & byte_mask(n)) | ({$urandom, $urandom} & ~byte_mask(n));
    hi = (pool_hi[k] & byte_mask(n - 8)) | ({$urandom, $urandom} & ~byte_mask(n - 8));
    len = LenW'(n);
    if (n == NameBytes && $urandom_range(0, 3) == 0)
      len = LenW'($urandom_range(NameBytes + 1, 31));
    vt = ($urandom_range(0, 7) == 0) ? TypeW'($urandom_range(0, 7)) : pool_type[k];
    if (r < 55) act = ActFind;
    else if (r < 80) act = ActCreate;
    else if (r < 92) act = ActAlias;
    else if (r < 94) act = ActClear;
    else begin
      case ($urandom_range(0, 2))
        0: act = ActFind;
        1: act = ActCreate;
        default: act = ActAlias;
      endcase
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      len = LenW'($urandom_range(0, 31));
      vt = TypeW'($urandom_range(0, 7));
    end
  endtask

  // beat monitor: predict on input beats, check on result beats
  always @(posedge clk) begin : beat_monitor
    slot_result_t want;
    slot_result_t oldest;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        lookup_symbol(in_action, in_name_low, in_name_high, in_name_length, in_var_type, want);
        if (beat_typed) begin
          want.slot = beat_slot;
          want.status = beat_status;
        end
        expected_results.push_back(want);
        status_tally[int'(want.status)]++;
        items_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result with nothing pending: slot %0d status %0d",
                                 out_slot_index, out_status));
        end else begin
          oldest = expected_results.pop_front();
          if (out_slot_index !== oldest.slot || out_status !== oldest.status)
            note_failure($sformatf("result %0d: expected slot %0d status %0d, got slot %0d status %0d",
                                   results_seen, oldest.slot, oldest.status,
                                   out_slot_index, out_status));
        end
        results_seen++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin : receiver
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin : watchdog
    wait (rst_n === 1'b1);
    while (stall_cycles < StallLimit) @(posedge clk);
    $display("watchdog: no beat for %0d cycles", StallLimit);
    $display("TEST FAILED");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    logic [1:0]       act;
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [LenW-1:0]  len;
    logic [TypeW-1:0] vt;
    dir_row_t         row;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ActFind;
    in_name_low    = '0;
    in_name_high   = '0;
    in_name_length = '0;
    in_var_type    = '0;
    beat_typed     = 1'b0;
    beat_slot      = '0;
    beat_status    = ST_FOUND;
    for (int s = 0; s < TableSize; s++) tbl_used[s] = 1'b0;
    foreach (status_tally[s]) status_tally[s] = 0;

    // directed rows: the name "A" hashes to slot zero
    add_row(ActFind,   64'h41, 64'h0, 5'd1, 3'd0, 1'b1, 8'd0, ST_CREATED);
    add_row(ActFind,   64'h41, 64'h0, 5'd1, 3'd0, 1'b1, 8'd0, ST_FOUND);
    add_row(ActCreate, 64'h41, 64'h0, 5'd1, 3'd0, 1'b1, 8'd0, ST_DUPLICATE);
    // bytes past the length are ignored, code three finds
    add_row(ActAlias,  64'hFFFF_FFFF_FFFF_FF41, '1, 5'd1, 3'd0, 1'b1, 8'd0, ST_FOUND);
    // empty name collides with "A" and moves one slot on
    add_row(ActFind,   '1, '1, 5'd0, 3'd0, 1'b1, 8'd1, ST_CREATED);
    // same name, other type: third probe lands on slot three
    add_row(ActFind,   64'h41, 64'h0, 5'd1, 3'd7, 1'b1, 8'd3, ST_CREATED);
    add_row(ActFind,   '1, '1, 5'd16, 3'd7, 1'b0, '0, ST_FOUND);
    // length above sixteen acts as sixteen
    add_row(ActCreate, '1, '1, 5'd31, 3'd7, 1'b0, '0, ST_FOUND);
    add_row(ActFind,   '0, '0, 5'd16, 3'd0, 1'b0, '0, ST_FOUND);
    add_row(ActFind,   '0, '1, 5'd8, 3'd0, 1'b0, '0, ST_FOUND);
    add_row(ActCreate, 64'h4141_4141_4141_4141, 64'h4141_4141_4141_4141, 5'd16, 3'd2,
            1'b0, '0, ST_FOUND);
    add_row(ActCreate, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd9, 3'd5,
            1'b0, '0, ST_FOUND);
    add_row(ActCreate, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd9, 3'd5,
            1'b0, '0, ST_FOUND);
    add_row(ActFind,   64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd10, 3'd5,
            1'b0, '0, ST_FOUND);
    add_row(ActClear,  '1, '1, 5'd31, 3'd7, 1'b1, 8'd0, ST_CLEARED);
    add_row(ActFind,   64'h41, 64'h0, 5'd1, 3'd0, 1'b1, 8'd0, ST_CREATED);
    add_row(ActFind,   '0, '0, 5'd0, 3'd0, 1'b1, 8'd1, ST_CREATED);
    add_row(ActAlias,  64'h8080_8080_8080_8080, 64'h7F7F_7F7F_7F7F_7F7F, 5'd17, 3'd3,
            1'b0, '0, ST_FOUND);
    add_row(ActFind,   64'h5A, 64'h0, 5'd1, 3'd1, 1'b0, '0, ST_FOUND);
    add_row(ActClear,  '0, '0, 5'd0, 3'd0, 1'b1, 8'd0, ST_CLEARED);

    for (int k = 0; k < PoolSize; k++) begin
      pool_lo[k] = {$urandom, $urandom};
      pool_hi[k] = {$urandom, $urandom};
      pool_len[k] = (k < 4) ? NameBytes : $urandom_range(1, NameBytes);
      pool_type[k] = TypeW'($urandom_range(0, 7));
    end

    // reset
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      offer_request(row.action, row.lo, row.hi, row.len, row.vtype,
                    row.typed, row.slot, row.status);
    end

    // pooled names with noise, one long receiver hold-off on the way
    for (int i = 0; i < 380; i++) begin
      if (i == 120) hold_pending = 1'b1;
      make_pool_request(act, lo, hi, len, vt);
      offer_request(act, lo, hi, len, vt, 1'b0, '0, ST_FOUND);
    end

    // fill the whole table with fresh names, on past the point where it reports full
    offer_request(ActClear, '0, '0, 5'd0, 3'd0, 1'b1, 8'd0, ST_CLEARED);
    for (int i = 0; i < 290; i++) begin
      act = ($urandom_range(0, 3) == 0) ? ActFind : ActCreate;
      offer_request(act, {$urandom, $urandom}, {$urandom, $urandom},
                    LenW'($urandom_range(1, NameBytes)), TypeW'($urandom_range(0, 7)),
                    1'b0, '0, ST_FOUND);
    end
    // lookups against the full table
    for (int i = 0; i < 20; i++) begin
      make_pool_request(act, lo, hi, len, vt);
      if (act == ActClear) act = ActFind;
      offer_request(act, lo, hi, len, vt, 1'b0, '0, ST_FOUND);
    end
    offer_request(ActClear, '1, '1, 5'd16, 3'd7, 1'b1, 8'd0, ST_CLEARED);

    // last part at full rate on both sides
    calm = 1'b1;
    for (int i = 0; i < 190; i++) begin
      make_pool_request(act, lo, hi, len, vt);
      offer_request(act, lo, hi, len, vt, 1'b0, '0, ST_FOUND);
    end
    in_valid <= 1'b0;

    // drain
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("run: %0d requests, %0d results; created %0d, found %0d, duplicate %0d",
             items_taken, results_seen, status_tally[int'(ST_CREATED)],
             status_tally[int'(ST_FOUND)], status_tally[int'(ST_DUPLICATE)]);
    $display("run: table full %0d, clears %0d, mismatches %0d",
             status_tally[int'(ST_FULL)], status_tally[int'(ST_CLEARED)], fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
